### design/ega_pkg.sv
// ----------------------------------------------------------------------------
// ega_pkg
// Types and constants shared by the epsilon-greedy arm selector modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ega_pkg;

    // table and field sizes
    localparam int MAX_ARMS     = 128;
    localparam int MAX_CHANNELS = 8;
    localparam int ARM_W        = 7;
    localparam int CH_W         = 3;
    localparam int SCORE_W      = 16;
    localparam int ARMS_CFG_W   = 8;
    localparam int RATE_W       = 16;
    localparam int CHAN_CFG_W   = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    // opcodes
    localparam logic OP_SELECT = 1'b0;
    localparam logic OP_REWARD = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_ARMS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE_RATE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CHANNELS = 2'd2;

    // configuration reset values
    localparam logic [ARMS_CFG_W-1:0] ACTIVE_ARMS_RST     = 8'd100;
    localparam logic [RATE_W-1:0]     EXPLORE_RATE_RST    = 16'd6554;
    localparam logic [CHAN_CFG_W-1:0] ACTIVE_CHANNELS_RST = 4'd8;

    // score saturation limits
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = 16'sh7FFF;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = 16'sh8000;

    typedef struct packed {
        logic              opcode;
        logic [RATE_W-1:0] random_fraction;
        logic [ARM_W-1:0]  random_arm;
        logic              delivered;
    } ega_in_t;

    typedef struct packed {
        logic [ARM_W-1:0]          chosen_arm;
        logic                      explored;
        logic [CH_W-1:0]           channel_index;
        logic signed [SCORE_W-1:0] arm_score;
    } ega_out_t;

    typedef struct packed {
        logic [ARMS_CFG_W-1:0] active_arms;
        logic [RATE_W-1:0]     explore_rate;
        logic [CHAN_CFG_W-1:0] active_channels;
    } ega_cfg_t;

    typedef struct packed {
        logic                      rd_en;
        logic [ARM_W-1:0]          rd_addr;
        logic                      wr_en;
        logic [ARM_W-1:0]          wr_addr;
        logic signed [SCORE_W-1:0] wr_data;
    } ega_mem_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PICK,
        ST_EXP_RD,
        ST_SCAN,
        ST_REW_RD,
        ST_DONE
    } ega_state_t;

endpackage

`default_nettype wire

### design/epsilon_greedy_arm_selector.sv
// ----------------------------------------------------------------------------
// epsilon_greedy_arm_selector
// Epsilon-greedy multi-armed bandit arm selector with a per-arm score table.
// Input channel s_*: one item per handshake. A select item explores with the
// supplied random arm when random_fraction is below explore_rate, otherwise
// exploits the first arm of highest score, and hands out a round-robin channel
// index; a reward item adds +1 or -1, saturating, to the last chosen arm.
// Result channel m_*: exactly one result item per input item, in order.
// Config channel cfg_*: always ready; write only while the block is idle.
// After acceptance an item passes the pick state, then a read state for an
// explore select or a reward, or, for an exploit select, a scan that reads the
// score memory one entry per cycle, before the result register loads; the
// next item is taken only after that, once the block is back in idle.
// When the receiver stalls, the result holds and one further finished item
// waits inside the block before the input stalls. Reset clears all scores to
// zero (per-entry valid flags, no clearing pass), the last arm and the channel
// counter, and loads the configuration defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module epsilon_greedy_arm_selector (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire ega_pkg::ega_in_t                  s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output ega_pkg::ega_out_t                      m_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ega_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ega_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ega_pkg::*;

    logic [ARMS_CFG_W-1:0]     active_arms_reg;
    logic [RATE_W-1:0]         explore_rate_reg;
    logic [CHAN_CFG_W-1:0]     active_channels_reg;
    ega_cfg_t                  cfg;
    ega_mem_req_t              mem_req;
    logic signed [SCORE_W-1:0] mem_rd_data;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_arms_reg     <= ACTIVE_ARMS_RST;
            explore_rate_reg    <= EXPLORE_RATE_RST;
            active_channels_reg <= ACTIVE_CHANNELS_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ACTIVE_ARMS:     active_arms_reg     <= cfg_data[ARMS_CFG_W-1:0];
                CFG_EXPLORE_RATE:    explore_rate_reg    <= cfg_data[RATE_W-1:0];
                CFG_ACTIVE_CHANNELS: active_channels_reg <= cfg_data[CHAN_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.active_arms     = active_arms_reg;
    assign cfg.explore_rate    = explore_rate_reg;
    assign cfg.active_channels = active_channels_reg;

    // sequencer
    ega_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data)
    );

    // score table
    ega_score_mem u_score_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

endmodule

`default_nettype wire

### design/ega_score_mem.sv
// ----------------------------------------------------------------------------
// ega_score_mem
// Score table: one write port, one registered read port, per-entry valid
// bits so that entries never written read back as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module ega_score_mem (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire ega_pkg::ega_mem_req_t          req,
    output logic signed [ega_pkg::SCORE_W-1:0]  rd_data
);
    import ega_pkg::*;

    logic signed [SCORE_W-1:0] mem [MAX_ARMS];
    logic [MAX_ARMS-1:0]       valid_reg;
    logic signed [SCORE_W-1:0] q_reg;
    logic                      hit_reg;

    // storage array and read data
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            q_reg <= mem[req.rd_addr];
        end
    end

    // written-entry flags, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end else begin
            if (req.wr_en) begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en) begin
                hit_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = hit_reg ? q_reg : '0;

endmodule

`default_nettype wire

### design/ega_ctrl.sv
// ----------------------------------------------------------------------------
// ega_ctrl
// Item sequencer: explore decision, score scan, reward read-modify-write,
// round-robin channel counter and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ega_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire ega_pkg::ega_cfg_t             cfg,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire ega_pkg::ega_in_t              s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output ega_pkg::ega_out_t                  m_data,
    output ega_pkg::ega_mem_req_t              mem_req,
    input  wire logic signed [ega_pkg::SCORE_W-1:0] mem_rd_data
);
    import ega_pkg::*;

    ega_state_t                state_reg, state_next;
    ega_in_t                   item_reg;
    ega_out_t                  res_reg;
    ega_out_t                  out_reg;
    logic                      out_valid_reg;
    logic [ARM_W-1:0]          last_arm_reg;
    logic [CH_W-1:0]           chan_reg;
    logic [ARM_W-1:0]          issue_idx_reg;
    logic                      issue_done_reg;
    logic                      pend_reg;
    logic [ARM_W-1:0]          pend_idx_reg;
    logic [ARM_W-1:0]          best_arm_reg;
    logic signed [SCORE_W-1:0] best_score_reg;

    logic [ARMS_CFG_W-1:0]     arms_eff;
    logic [ARMS_CFG_W-1:0]     arms_m1;
    logic [CHAN_CFG_W-1:0]     chans_eff;
    logic                      explore;
    logic                      is_reward;
    logic [ARM_W-1:0]          explore_arm;
    logic [CH_W-1:0]           chan_use;
    logic [CHAN_CFG_W-1:0]     chan_inc;
    logic [CH_W-1:0]           chan_after;
    logic                      take_new;
    logic [ARM_W-1:0]          win_arm;
    logic signed [SCORE_W-1:0] win_score;
    logic signed [SCORE_W-1:0] rew_score;
    logic                      scan_last;
    logic                      out_load;

    // effective arm and channel counts
    always_comb begin
        if (cfg.active_arms == '0) begin
            arms_eff = ARMS_CFG_W'(1);
        end else if (cfg.active_arms > ARMS_CFG_W'(MAX_ARMS)) begin
            arms_eff = ARMS_CFG_W'(MAX_ARMS);
        end else begin
            arms_eff = cfg.active_arms;
        end
        if (cfg.active_channels == '0) begin
            chans_eff = CHAN_CFG_W'(1);
        end else if (cfg.active_channels > CHAN_CFG_W'(MAX_CHANNELS)) begin
            chans_eff = CHAN_CFG_W'(MAX_CHANNELS);
        end else begin
            chans_eff = cfg.active_channels;
        end
    end

    assign arms_m1   = arms_eff - ARMS_CFG_W'(1);
    assign is_reward = (item_reg.opcode == OP_REWARD);
    assign explore   = (item_reg.random_fraction < cfg.explore_rate);

    // exploration arm, clamped to the highest active arm
    assign explore_arm = ({1'b0, item_reg.random_arm} > arms_m1) ?
                         arms_m1[ARM_W-1:0] : item_reg.random_arm;

    // round robin, restarting when the count has shrunk to or below the counter
    assign chan_use   = ({1'b0, chan_reg} >= chans_eff) ? '0 : chan_reg;
    assign chan_inc   = {1'b0, chan_use} + CHAN_CFG_W'(1);
    assign chan_after = (chan_inc >= chans_eff) ? '0 : chan_inc[CH_W-1:0];

    // scan compare: first entry seeds, later ones win only when strictly larger
    assign take_new  = pend_reg && ((pend_idx_reg == '0) || (mem_rd_data > best_score_reg));
    assign win_arm   = take_new ? pend_idx_reg : best_arm_reg;
    assign win_score = take_new ? mem_rd_data : best_score_reg;
    assign scan_last = issue_done_reg && pend_reg;

    // saturating reward update
    always_comb begin
        if (item_reg.delivered) begin
            rew_score = (mem_rd_data == SCORE_MAX) ? mem_rd_data : mem_rd_data + 16'sd1;
        end else begin
            rew_score = (mem_rd_data == SCORE_MIN) ? mem_rd_data : mem_rd_data - 16'sd1;
        end
    end

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_ready);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK: begin
                if (is_reward) begin
                    state_next = ST_REW_RD;
                end else if (explore) begin
                    state_next = ST_EXP_RD;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_EXP_RD: state_next = ST_DONE;
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_REW_RD: state_next = ST_DONE;
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs: handshake and memory requests
    always_comb begin
        s_ready         = 1'b0;
        mem_req         = '0;
        mem_req.rd_addr = issue_idx_reg;
        mem_req.wr_addr = last_arm_reg;
        mem_req.wr_data = rew_score;
        unique case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_PICK: begin
                if (is_reward) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = last_arm_reg;
                end else if (explore) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = explore_arm;
                end
            end
            ST_SCAN: mem_req.rd_en = !issue_done_reg;
            ST_REW_RD: mem_req.wr_en = 1'b1;
            ST_EXP_RD, ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            last_arm_reg   <= '0;
            chan_reg       <= '0;
            issue_done_reg <= 1'b0;
            pend_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_PICK && !is_reward) begin
                chan_reg <= chan_after;
                if (explore) begin
                    last_arm_reg <= explore_arm;
                end
            end
            if (state_reg == ST_SCAN && scan_last) begin
                last_arm_reg <= win_arm;
            end
            // scan sequencing
            if (state_reg == ST_PICK) begin
                issue_done_reg <= 1'b0;
                pend_reg       <= 1'b0;
            end else if (state_reg == ST_SCAN) begin
                pend_reg <= !issue_done_reg;
                if (!issue_done_reg && (issue_idx_reg == arms_m1[ARM_W-1:0])) begin
                    issue_done_reg <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            item_reg <= s_data;
        end
        if (state_reg == ST_PICK) begin
            issue_idx_reg          <= '0;
            res_reg.chosen_arm     <= is_reward ? last_arm_reg : explore_arm;
            res_reg.explored       <= !is_reward && explore;
            res_reg.channel_index  <= is_reward ? '0 : chan_use;
        end
        if (state_reg == ST_SCAN) begin
            if (!issue_done_reg) begin
                issue_idx_reg <= issue_idx_reg + ARM_W'(1);
            end
            pend_idx_reg   <= issue_idx_reg;
            best_arm_reg   <= win_arm;
            best_score_reg <= win_score;
            if (scan_last) begin
                res_reg.chosen_arm <= win_arm;
                res_reg.arm_score  <= win_score;
            end
        end
        if (state_reg == ST_EXP_RD) begin
            res_reg.arm_score <= mem_rd_data;
        end
        if (state_reg == ST_REW_RD) begin
            res_reg.arm_score <= rew_score;
        end
        if (out_load) begin
            out_reg <= res_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

### verif/epsilon_greedy_arm_selector_test.sv
// ----------------------------------------------------------------------------
// epsilon_greedy_arm_selector_test
// Self-checking bench for the epsilon-greedy arm selector. A score tracker
// mirrors the per-arm score table, last arm and channel counter, predicts
// the result of every accepted item and compares the results in order.
// Directed items hit the edge cases first. Random phases at varied settings
// follow, with random idling on both sides and one long receiver hold-off.
// A short random tail at a mid explore rate closes the run.
// ----------------------------------------------------------------------------
`default_nettype none

module epsilon_greedy_arm_selector_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ega_pkg::*;

    localparam int CYCLE_LIMIT  = 3000000;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 145;
    localparam int DRAIN_CYCLES = MAX_ARMS + 12;
    localparam int MAX_REPORTS  = 100;

    // score tracker: mirrors the block state and checks result items
    class arm_score_tracker;
        logic signed [SCORE_W-1:0] scores [MAX_ARMS];
        int                        last_arm;
        int                        chan_ctr;
        logic [ARMS_CFG_W-1:0]     arms_reg;
        logic [RATE_W-1:0]         rate_reg;
        logic [CHAN_CFG_W-1:0]     chans_reg;
        ega_out_t                  expected_picks [$];
        int                        mismatches;
        int                        checked;

        function new();
            foreach (scores[i]) scores[i] = '0;
            last_arm   = 0;
            chan_ctr   = 0;
            arms_reg   = ACTIVE_ARMS_RST;
            rate_reg   = EXPLORE_RATE_RST;
            chans_reg  = ACTIVE_CHANNELS_RST;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_ACTIVE_ARMS:     arms_reg  = val[ARMS_CFG_W-1:0];
                CFG_EXPLORE_RATE:    rate_reg  = val[RATE_W-1:0];
                CFG_ACTIVE_CHANNELS: chans_reg = val[CHAN_CFG_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_picks.size();
        endfunction

        // work out the result of one accepted item
        function void note_item(ega_in_t req);
            ega_out_t                  res;
            int                        n;
            int                        nch;
            int                        arm;
            logic signed [SCORE_W-1:0] s;
            n   = (arms_reg == 0) ? 1 : ((arms_reg > MAX_ARMS) ? MAX_ARMS : int'(arms_reg));
            nch = (chans_reg == 0) ? 1 :
                  ((chans_reg > MAX_CHANNELS) ? MAX_CHANNELS : int'(chans_reg));
            if (req.opcode == OP_SELECT) begin
                if (req.random_fraction < rate_reg) begin
                    res.explored = 1'b1;
                    arm = (int'(req.random_arm) > n - 1) ? n - 1 : int'(req.random_arm);
                end else begin
                    // first arm of highest score
                    res.explored = 1'b0;
                    arm = 0;
                    for (int i = 1; i < n; i++)
                        if (scores[i] > scores[arm]) arm = i;
                end
                last_arm = arm;
                if (chan_ctr >= nch) chan_ctr = 0;
                res.channel_index = chan_ctr[CH_W-1:0];
                chan_ctr = (chan_ctr + 1 >= nch) ? 0 : chan_ctr + 1;
                res.chosen_arm = arm[ARM_W-1:0];
                res.arm_score  = scores[arm];
            end else begin
                // reward with saturation at the 16-bit limits
                s = scores[last_arm];
                if (req.delivered) begin
                    if (s != SCORE_MAX) s = s + 16'sd1;
                end else begin
                    if (s != SCORE_MIN) s = s - 16'sd1;
                end
                scores[last_arm]  = s;
                res.chosen_arm    = last_arm[ARM_W-1:0];
                res.explored      = 1'b0;
                res.channel_index = '0;
                res.arm_score     = s;
            end
            expected_picks = {expected_picks, res};
        endfunction

        // compare one result item with the oldest prediction
        function void check_item(ega_out_t got);
            ega_out_t want;
            bit       bad;
            checked++;
            if (expected_picks.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $error("unexpected result item: arm %0d score %0d",
                           got.chosen_arm, got.arm_score);
                return;
            end
            want = expected_picks.pop_front();
            bad  = 1'b0;
            if (got.chosen_arm !== want.chosen_arm) begin
                bad = 1'b1;
                if (mismatches < MAX_REPORTS)
                    $error("chosen_arm: expected %0d, got %0d", want.chosen_arm, got.chosen_arm);
            end
            if (got.explored !== want.explored) begin
                bad = 1'b1;
                if (mismatches < MAX_REPORTS)
                    $error("explored: expected %0d, got %0d", want.explored, got.explored);
            end
            if (got.channel_index !== want.channel_index) begin
                bad = 1'b1;
                if (mismatches < MAX_REPORTS)
                    $error("channel_index: expected %0d, got %0d",
                           want.channel_index, got.channel_index);
            end
            if (got.arm_score !== want.arm_score) begin
                bad = 1'b1;
                if (mismatches < MAX_REPORTS)
                    $error("arm_score: expected %0d, got %0d", want.arm_score, got.arm_score);
            end
            if (bad) mismatches++;
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    ega_in_t               s_data;
    logic                  m_valid;
    logic                  m_ready;
    ega_out_t              m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    arm_score_tracker tracker = new();
    bit               calm    = 1'b0;
    int               cycle_count = 0;

    epsilon_greedy_arm_selector u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // cycle limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[epsilon_greedy_arm_selector] ERROR");
        $finish;
    end

    // result side: random back-pressure plus one long hold-off
    initial begin : result_sink
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) tracker.check_item(m_data);
            if (!held && tracker.checked >= 400) begin
                held      = 1'b1;
                hold_left = 500;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= 38);
            end
        end
    end

    function automatic ega_in_t make_req(logic op, logic [RATE_W-1:0] frac,
                                         logic [ARM_W-1:0] rarm, logic del);
        ega_in_t r;
        r.opcode          = op;
        r.random_fraction = frac;
        r.random_arm      = rarm;
        r.delivered       = del;
        return r;
    endfunction

    // random item, fraction often right around the explore threshold
    function automatic ega_in_t random_req(int up_pct, logic [RATE_W-1:0] rate);
        ega_in_t r;
        r.opcode          = ($urandom_range(99) < 50) ? OP_REWARD : OP_SELECT;
        r.random_fraction = RATE_W'($urandom);
        if ($urandom_range(3) == 0)
            r.random_fraction = rate + RATE_W'($urandom_range(2)) - 1'b1;
        r.random_arm      = ARM_W'($urandom);
        r.delivered       = ($urandom_range(99) < up_pct);
        return r;
    endfunction

    // offer one item, with an optional gap first; valid is left high
    task automatic send_item(input ega_in_t req);
        while (!calm && $urandom_range(99) < 38) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.note_item(req);
    endtask

    // wait for every result, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        while (tracker.pending() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // write all three registers back to back, block idle
    task automatic write_config(input logic [CFG_DATA_W-1:0] arms,
                                input logic [CFG_DATA_W-1:0] rate,
                                input logic [CFG_DATA_W-1:0] chans);
        logic [CFG_IDX_W-1:0]  idx [3];
        logic [CFG_DATA_W-1:0] val [3];
        idx[0] = CFG_ACTIVE_ARMS;     val[0] = arms;
        idx[1] = CFG_EXPLORE_RATE;    val[1] = rate;
        idx[2] = CFG_ACTIVE_CHANNELS; val[2] = chans;
        cfg_valid <= 1'b1;
        for (int k = 0; k < 3; k++) begin
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            tracker.set_reg(idx[k], val[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    // stimulus
    initial begin : stimulus
        logic [7:0]  arms;
        logic [15:0] rate;
        logic [3:0]  chans;
        int          up_pct;

        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // reset settings: reward before any select, threshold edges, clamp
        send_item(make_req(OP_REWARD, 16'h0000, 7'd0, 1'b0));
        send_item(make_req(OP_REWARD, 16'hFFFF, 7'd0, 1'b1));
        send_item(make_req(OP_SELECT, 16'hFFFF, 7'd0, 1'b0));
        send_item(make_req(OP_SELECT, 16'h0000, 7'd127, 1'b1));
        send_item(make_req(OP_REWARD, 16'h0000, 7'd0, 1'b1));
        send_item(make_req(OP_SELECT, EXPLORE_RATE_RST, 7'd127, 1'b0));
        send_item(make_req(OP_SELECT, EXPLORE_RATE_RST - 16'd1, 7'd5, 1'b0));
        send_item(make_req(OP_REWARD, 16'h0000, 7'd0, 1'b0));
        drain();

        // zero counts act as one, explore rate at full scale
        write_config(16'hFF00, 16'hFFFF, 16'hFFF0);
        send_item(make_req(OP_SELECT, 16'h0000, 7'd127, 1'b0));
        send_item(make_req(OP_SELECT, 16'hFFFF, 7'd127, 1'b0));
        send_item(make_req(OP_REWARD, 16'h0000, 7'd0, 1'b1));
        drain();

        // counts above the maximum, never explore
        write_config(16'h00FF, 16'h0000, 16'h000F);
        send_item(make_req(OP_SELECT, 16'h0000, 7'd0, 1'b0));
        send_item(make_req(OP_REWARD, 16'h0000, 7'd0, 1'b0));
        send_item(make_req(OP_SELECT, 16'h0000, 7'd127, 1'b1));
        drain();

        // full arm count, three channels
        write_config(16'd128, 16'hFFFF, 16'd3);
        send_item(make_req(OP_SELECT, 16'h0000, 7'd127, 1'b0));
        send_item(make_req(OP_REWARD, 16'h0000, 7'd0, 1'b1));
        send_item(make_req(OP_SELECT, 16'hFFFF, 7'd0, 1'b0));
        drain();

        // arm count shrinks below the last arm, channel count shrinks
        write_config(16'd2, 16'hFFFF, 16'd1);
        send_item(make_req(OP_REWARD, 16'h0000, 7'd0, 1'b1));
        send_item(make_req(OP_SELECT, 16'hFFFF, 7'd127, 1'b0));
        send_item(make_req(OP_SELECT, 16'h0000, 7'd127, 1'b1));
        drain();

        // random phases at varied settings
        for (int p = 0; p < PHASES; p++) begin
            case ($urandom_range(9))
                0:       arms = 8'd0;
                1:       arms = 8'd128;
                2:       arms = 8'($urandom_range(129, 255));
                3:       arms = 8'd1;
                default: arms = 8'($urandom_range(2, 12));
            endcase
            case ($urandom_range(5))
                0:       rate = 16'h0000;
                1:       rate = 16'hFFFF;
                default: rate = 16'($urandom);
            endcase
            chans  = 4'($urandom_range(15));
            up_pct = $urandom_range(20, 80);
            write_config({8'($urandom), arms}, rate, {12'($urandom), chans});
            calm = (p == 4);
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_item(random_req(up_pct, tracker.rate_reg));
            drain();
            calm = 1'b0;
        end

        // short random tail at a mid explore rate
        write_config(16'd8, 16'h8000, 16'd8);
        for (int k = 0; k < 40; k++)
            send_item(random_req(50, tracker.rate_reg));
        drain();

        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("[epsilon_greedy_arm_selector] OK");
        else
            $display("[epsilon_greedy_arm_selector] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
